// ----- design/priority_ready_queue_scheduler_core_assert.svh -----
// assertion macros for the ready-queue scheduler
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define PRQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked on the clock after the antecedent
`define PRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/prqs_pkg.sv -----
// ---------------------------------------------------------------------------
// prqs_pkg
// shared constants, types and codes of the ready-queue scheduler
// ---------------------------------------------------------------------------
package prqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int LEVELS      = 3;
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [FILL_BITS-1:0] fill_type;

   // command codes
   localparam logic [2:0] MODE_CREATE  = 3'd0;
   localparam logic [2:0] MODE_FORK    = 3'd1;
   localparam logic [2:0] MODE_KILL    = 3'd2;
   localparam logic [2:0] MODE_EXIT    = 3'd3;
   localparam logic [2:0] MODE_QUANTUM = 3'd4;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_FAIL   = 2'd1;
   localparam logic [1:0] ST_OTHERS = 2'd2;
   localparam logic [1:0] ST_IDLEX  = 2'd3;

   // idle process states
   localparam logic [1:0] IDLE_RUNNING = 2'd0;
   localparam logic [1:0] IDLE_READY   = 2'd1;
   localparam logic [1:0] IDLE_BLOCKED = 2'd2;

   // per-level queue operations
   typedef enum logic [1:0] {
      QOP_NONE,
      QOP_PUSH,
      QOP_POP,
      QOP_KILL
   } qop_type;

   // command to one level's cell chain
   typedef struct packed {
      qop_type op;
      id_type  id;
   } qcmd_type;

   // status from one level's cell chain
   typedef struct packed {
      fill_type fill;
      id_type   head;
      logic     hit;
   } qstat_type;

endpackage

// ----- design/prqs_if.sv -----
// ---------------------------------------------------------------------------
// prqs_req_if / prqs_rsp_if
// valid/ready channels of the scheduler
// ---------------------------------------------------------------------------
interface prqs_req_if;
   import prqs_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [1:0] level;
   id_type     target_pid;
   logic       blocked_elsewhere;
   modport source (output valid, mode, level, target_pid, blocked_elsewhere, input ready);
   modport sink   (input valid, mode, level, target_pid, blocked_elsewhere, output ready);
endinterface

interface prqs_rsp_if;
   import prqs_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   id_type     result_pid;
   id_type     running_pid;
   logic [1:0] running_level;
   logic       idle_exited;
   modport source (output valid, status, result_pid, running_pid, running_level,
                   idle_exited, input ready);
   modport sink   (input valid, status, result_pid, running_pid, running_level,
                   idle_exited, output ready);
endinterface

// ----- design/prqs_cell.sv -----
// ---------------------------------------------------------------------------
// prqs_cell
// one slot of a level queue; shifts toward the head on pop or removal
// ---------------------------------------------------------------------------
module prqs_cell
   import prqs_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   occ_left,   // slot nearer the head is occupied
   input  logic   kill_left,  // a slot nearer the head matches or is removed
   input  qop_type op,
   input  id_type cmd_id,
   input  logic   push_here,  // this slot is the tail for a push
   input  id_type id_right,   // neighbor toward the tail
   input  logic   occ_right,
   output id_type id_out,
   output logic   occ_out,
   output logic   kill_out    // removal point at or before this slot
);

   id_type id_ff, id_in;
   logic   occ_ff, occ_in;
   logic   match;

   assign match    = occ_ff && (id_ff == cmd_id) && (op == QOP_KILL);
   assign kill_out = kill_left || match;
   assign id_out   = id_ff;
   assign occ_out  = occ_ff;

   // next slot content
   always_comb begin
      id_in  = id_ff;
      occ_in = occ_ff;
      unique case (op)
         QOP_PUSH: begin
            if (push_here) begin
               id_in  = cmd_id;
               occ_in = 1'b1;
            end
         end
         QOP_POP: begin
            id_in  = id_right;
            occ_in = occ_right;
         end
         QOP_KILL: begin
            if (kill_out) begin
               id_in  = id_right;
               occ_in = occ_right;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) occ_ff <= 1'b0;
      else       occ_ff <= occ_in;
   end

   `include "priority_ready_queue_scheduler_core_assert.svh"
   `PRQS_ASSERT_IMPL(a_cell_packed, clock, reset, occ_ff, occ_left, "hole in queue")

endmodule

// ----- design/prqs_queue.sv -----
// ---------------------------------------------------------------------------
// prqs_queue
// one priority level: a chain of cells with head at index 0
// ---------------------------------------------------------------------------
module prqs_queue
   import prqs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qcmd_type  cmd,
   input  id_type    search_id,
   output qstat_type stat
);

   id_type ids  [QUEUE_DEPTH];
   logic   occ  [QUEUE_DEPTH];
   logic   kil  [QUEUE_DEPTH];
   fill_type fill_ff, fill_in;
   logic   hit;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic   ol, kl, orr;
         id_type ir;
         if (g == 0) begin : g_head
            assign ol = 1'b1;
            assign kl = 1'b0;
         end else begin : g_body
            assign ol = occ[g-1];
            assign kl = kil[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign ir  = '0;
            assign orr = 1'b0;
         end else begin : g_mid
            assign ir  = ids[g+1];
            assign orr = occ[g+1];
         end
         prqs_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .occ_left  (ol),
            .kill_left (kl),
            .op        (cmd.op),
            .cmd_id    (cmd.id),
            .push_here (fill_ff == FILL_BITS'(g)),
            .id_right  (ir),
            .occ_right (orr),
            .id_out    (ids[g]),
            .occ_out   (occ[g]),
            .kill_out  (kil[g])
         );
      end
   endgenerate

   // fill tracking
   always_comb begin
      fill_in = fill_ff;
      unique case (cmd.op)
         QOP_PUSH: if (fill_ff != FILL_BITS'(QUEUE_DEPTH)) fill_in = fill_ff + 1'b1;
         QOP_POP:  if (fill_ff != '0) fill_in = fill_ff - 1'b1;
         QOP_KILL: if (kil[QUEUE_DEPTH-1]) fill_in = fill_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   // search for an id without changing anything
   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < QUEUE_DEPTH; k++)
         if (occ[k] && ids[k] == search_id) hit = 1'b1;
   end

   assign stat = '{fill: fill_ff, head: ids[0], hit: hit};

   `include "priority_ready_queue_scheduler_core_assert.svh"
   `PRQS_ASSERT_IMPL(a_fill_range, clock, reset, 1'b1, fill_ff <= FILL_BITS'(QUEUE_DEPTH), "fill over depth")
   `PRQS_ASSERT_IMPL(a_head_occ, clock, reset, fill_ff != '0, occ[0], "head empty while filled")

endmodule

// ----- design/priority_ready_queue_scheduler_core.sv -----
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler_core
// three-level strict-priority ready-queue scheduler with an idle process
// ---------------------------------------------------------------------------
// A command beat gives its result beat after S_EXEC and S_OUT, with S_SCHED
// between them when the runner leaves: S_EXEC decodes and issues a queue
// operation to the level's chain of cells (search, push or shift), S_SCHED
// pops the successor from the highest non-empty level, and S_OUT lets the
// chains settle and loads the output register. The result beat is held in that
// register, and the next command is accepted in the cycle after it is taken.
module priority_ready_queue_scheduler_core
   import prqs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   prqs_req_if.sink   req,
   prqs_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_SCHED = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] mode_ff;
   logic [1:0] lvl_ff;
   id_type     tgt_ff;
   logic       else_ff;

   id_type     next_ff, next_in;
   id_type     cur_ff, cur_in;
   logic [1:0] clvl_ff, clvl_in;
   logic [1:0] idle_ff, idle_in;
   logic [1:0] st_ff, st_in;
   id_type     rpid_ff, rpid_in;
   logic       ov_ff, ov_in;

   qcmd_type  qcmd [LEVELS];
   qstat_type qst  [LEVELS];

   genvar l;
   generate
      for (l = 0; l < LEVELS; l++) begin : g_lvl
         prqs_queue u_queue (.clock(clock), .reset(reset), .cmd(qcmd[l]),
                             .search_id(tgt_ff), .stat(qst[l]));
      end
   endgenerate

   logic   empty_all;
   id_type nid_inc;
   assign empty_all = (qst[0].fill == '0) && (qst[1].fill == '0) && (qst[2].fill == '0);
   assign nid_inc   = (next_ff + 1'b1 == '0) ? id_type'(1) : next_ff + 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !ov_ff;

   // command sequencing
   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      cur_in   = cur_ff;
      clvl_in  = clvl_ff;
      idle_in  = idle_ff;
      st_in    = st_ff;
      rpid_in  = rpid_ff;
      ov_in    = ov_ff;
      for (int k = 0; k < LEVELS; k++) qcmd[k] = '{op: QOP_NONE, id: tgt_ff};
      if (rsp.valid && rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_EXEC;
         S_EXEC: begin
            st_in    = ST_FAIL;
            rpid_in  = '0;
            state_in = S_OUT;
            priority case (mode_ff)
               MODE_CREATE: if (lvl_ff != 2'd3) begin
                  if (idle_ff == IDLE_RUNNING) begin
                     idle_in = IDLE_READY;
                     cur_in  = next_ff;
                     clvl_in = lvl_ff;
                     rpid_in = next_ff;
                     next_in = nid_inc;
                     st_in   = ST_DONE;
                  end else if (qst[lvl_ff].fill != FILL_BITS'(QUEUE_DEPTH)) begin
                     qcmd[lvl_ff] = '{op: QOP_PUSH, id: next_ff};
                     rpid_in = next_ff;
                     next_in = nid_inc;
                     st_in   = ST_DONE;
                  end
               end
               MODE_FORK: if (idle_ff != IDLE_RUNNING &&
                              qst[clvl_ff].fill != FILL_BITS'(QUEUE_DEPTH)) begin
                  qcmd[clvl_ff] = '{op: QOP_PUSH, id: next_ff};
                  rpid_in = next_ff;
                  next_in = nid_inc;
                  st_in   = ST_DONE;
               end
               MODE_KILL: begin
                  if (tgt_ff == '0) begin
                     if (empty_all && !else_ff && idle_ff != IDLE_READY) begin
                        idle_in = IDLE_BLOCKED;
                        st_in   = ST_IDLEX;
                     end else st_in = ST_OTHERS;
                  end else if (tgt_ff == cur_ff) begin
                     rpid_in  = tgt_ff;
                     st_in    = ST_DONE;
                     state_in = S_SCHED;
                  end else if (qst[0].hit) begin
                     qcmd[0] = '{op: QOP_KILL, id: tgt_ff};
                     rpid_in = tgt_ff; st_in = ST_DONE;
                  end else if (qst[1].hit) begin
                     qcmd[1] = '{op: QOP_KILL, id: tgt_ff};
                     rpid_in = tgt_ff; st_in = ST_DONE;
                  end else if (qst[2].hit) begin
                     qcmd[2] = '{op: QOP_KILL, id: tgt_ff};
                     rpid_in = tgt_ff; st_in = ST_DONE;
                  end
               end
               MODE_EXIT: begin
                  if (cur_ff == '0) begin
                     if (empty_all && !else_ff) begin
                        idle_in = IDLE_BLOCKED;
                        st_in   = ST_IDLEX;
                     end else st_in = ST_OTHERS;
                  end else begin
                     rpid_in  = cur_ff;
                     st_in    = ST_DONE;
                     state_in = S_SCHED;
                  end
               end
               MODE_QUANTUM: begin
                  if (cur_ff != '0 && qst[clvl_ff].fill == FILL_BITS'(QUEUE_DEPTH)) begin
                     rpid_in = cur_ff;
                     st_in   = ST_FAIL;
                  end else begin
                     if (cur_ff != '0) qcmd[clvl_ff] = '{op: QOP_PUSH, id: cur_ff};
                     st_in    = ST_DONE;
                     state_in = S_SCHED;
                  end
               end
               default: ;
            endcase
         end
         S_SCHED: begin
            state_in = S_OUT;
            if (qst[0].fill != '0 || qst[1].fill != '0 || qst[2].fill != '0) begin
               priority if (qst[0].fill != '0) begin
                  cur_in = qst[0].head; clvl_in = 2'd0; qcmd[0].op = QOP_POP;
               end else if (qst[1].fill != '0) begin
                  cur_in = qst[1].head; clvl_in = 2'd1; qcmd[1].op = QOP_POP;
               end else begin
                  cur_in = qst[2].head; clvl_in = 2'd2; qcmd[2].op = QOP_POP;
               end
               idle_in = IDLE_READY;
            end else begin
               cur_in  = '0;
               clvl_in = 2'd0;
               idle_in = IDLE_RUNNING;
            end
            if (mode_ff == MODE_QUANTUM) rpid_in = cur_in;
         end
         S_OUT: begin
            ov_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         mode_ff <= req.mode;
         lvl_ff  <= req.level;
         tgt_ff  <= req.target_pid;
         else_ff <= req.blocked_elsewhere;
      end
      st_ff   <= st_in;
      rpid_ff <= rpid_in;
      if (reset) begin
         state_ff <= S_IDLE;
         next_ff  <= id_type'(1);
         cur_ff   <= '0;
         clvl_ff  <= '0;
         idle_ff  <= IDLE_RUNNING;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         cur_ff   <= cur_in;
         clvl_ff  <= clvl_in;
         idle_ff  <= idle_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp.valid         = ov_ff;
   assign rsp.status        = st_ff;
   assign rsp.result_pid    = rpid_ff;
   assign rsp.running_pid   = cur_ff;
   assign rsp.running_level = clvl_ff;
   assign rsp.idle_exited   = (idle_ff == IDLE_BLOCKED);

   `include "priority_ready_queue_scheduler_core_assert.svh"
   `PRQS_ASSERT_IMPL(a_next_nonzero, clock, reset, 1'b1, next_ff != '0, "next id is zero")
   `PRQS_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req.ready, "ready while busy")
   `PRQS_ASSERT_NEXT(a_exec_follows, clock, reset, req.valid && req.ready, state_ff == S_EXEC, "no exec")
   `PRQS_ASSERT_IMPL(a_idle_level, clock, reset, cur_ff == '0, clvl_ff == '0, "idle not at level 0")

endmodule
